// ===== rtl/core/wfr_pkg.sv =====
// shared types, constants and the crc-8 helper for the wake frame receiver
package wfr_pkg;

  localparam logic [7:0] FEND_BYTE  = 8'hC0;
  localparam logic [7:0] FESC_BYTE  = 8'hDB;
  localparam logic [7:0] TFEND_BYTE = 8'hDC;
  localparam logic [7:0] TFESC_BYTE = 8'hDD;
  localparam logic [7:0] CRC_PRESET = 8'hDE;
  localparam logic [7:0] CRC_POLY   = 8'h18;

  // largest payload length that a count byte may declare
  localparam logic [8:0] MAX_PAYLOAD = 9'd255;

  typedef enum logic [2:0] {
    PH_IDLE  = 3'd0,
    PH_ADDR  = 3'd1,
    PH_CMD   = 3'd2,
    PH_COUNT = 3'd3,
    PH_DATA  = 3'd4
  } phase_t;

  typedef enum logic [1:0] {
    KIND_DATA   = 2'd0,
    KIND_ACCEPT = 2'd1,
    KIND_ERROR  = 2'd2
  } kind_t;

  // reflected crc-8, one bit per step, lsb first
  function automatic logic [7:0] crc_fold(input logic [7:0] crc_in, input logic [7:0] b_in);
    logic [7:0] crc;
    logic [7:0] b;
    crc = crc_in;
    b   = b_in;
    for (int i = 0; i < 8; i++) begin
      if ((b[0] ^ crc[0]) == 1'b1) begin
        crc = ((crc ^ CRC_POLY) >> 1) | 8'h80;
      end else begin
        crc = (crc >> 1) & 8'h7F;
      end
      b = b >> 1;
    end
    return crc;
  endfunction

endpackage

// ===== rtl/core/wfr_ifs.sv =====
// valid/ready channel interfaces for received bytes and frame results
interface wfr_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] rx_byte;

  modport source (output valid, output rx_byte, input ready);
  modport sink   (input valid, input rx_byte, output ready);
endinterface

interface wfr_out_if import wfr_pkg::*; ();
  logic       valid;
  logic       ready;
  kind_t      kind;
  logic [7:0] data_value;
  logic [7:0] data_index;
  logic [6:0] command_code;
  logic [7:0] payload_length;

  modport source (output valid, output kind, output data_value, output data_index,
                  output command_code, output payload_length, input ready);
  modport sink   (input valid, input kind, input data_value, input data_index,
                  input command_code, input payload_length, output ready);
endinterface

// ===== rtl/core/wake_frame_receiver.sv =====
// wake frame receiver: byte unstuffing, address filter, crc-8 check, result stream
//
//   channel  | dir | payload                                        | transfer
//   in_ch    | in  | rx_byte                                        | valid & ready
//   out_ch   | out | kind, data_value, data_index, command_code,    | valid & ready
//            |     | payload_length                                 |
//   cfg      | in  | cfg_wdata (own_address)                        | cfg_we
//
// one byte per cycle while out_ch does not stall; after its transfer a byte is held in the input register,
// then frame decode and crc fold move it into the result register
// rst_n is synchronous: clears the frame state, own_address and both valid flags
// a stalled result holds the input register; only then does in_ch.ready drop
module wake_frame_receiver import wfr_pkg::*; (
  input  logic            clk,
  input  logic            rst_n,
  wfr_in_if.sink          in_ch,
  wfr_out_if.source       out_ch,
  input  logic            cfg_we,
  input  logic [6:0]      cfg_wdata
);

  logic       in_valid_r;
  logic [7:0] in_byte_r;
  logic       consume;

  logic [6:0] own_addr_r;
  phase_t     phase_r, phase_nxt;
  logic [7:0] prev_r, prev_nxt;
  logic [7:0] crc_r, crc_nxt;
  logic [6:0] cmd_r, cmd_nxt;
  logic [7:0] len_r, len_nxt;
  logic [7:0] ptr_r, ptr_nxt;

  logic       res_valid;
  kind_t      res_kind;
  logic [7:0] res_value;
  logic [7:0] res_index;
  logic [6:0] res_cmd;
  logic [7:0] res_len;

  logic       out_valid_r;
  kind_t      out_kind_r;
  logic [7:0] out_value_r;
  logic [7:0] out_index_r;
  logic [6:0] out_cmd_r;
  logic [7:0] out_len_r;

  assign consume     = in_valid_r && (!out_valid_r || out_ch.ready);
  assign in_ch.ready = !in_valid_r || consume;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r <= 1'b0;
    end else if (in_ch.ready) begin
      in_valid_r <= in_ch.valid;
    end
    if (in_ch.ready) begin
      in_byte_r <= in_ch.rx_byte;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      own_addr_r <= '0;
    end else if (cfg_we) begin
      own_addr_r <= cfg_wdata;
    end
  end

  // frame decode for the byte in the input register
  always_comb begin
    logic [7:0] ub;
    logic       stop;
    phase_t     act_phase;
    logic [7:0] fold_byte;
    logic       fold_en;

    ub        = in_byte_r;
    stop      = 1'b0;
    act_phase = phase_r;
    fold_byte = in_byte_r;
    fold_en   = 1'b0;

    phase_nxt = phase_r;
    prev_nxt  = prev_r;
    crc_nxt   = crc_r;
    cmd_nxt   = cmd_r;
    len_nxt   = len_r;
    ptr_nxt   = ptr_r;

    res_valid = 1'b0;
    res_kind  = KIND_DATA;
    res_value = '0;
    res_index = '0;
    res_cmd   = '0;
    res_len   = '0;

    if (in_byte_r == FEND_BYTE) begin
      prev_nxt  = in_byte_r;
      crc_nxt   = crc_fold(CRC_PRESET, FEND_BYTE);
      phase_nxt = PH_ADDR;
    end else if (phase_r != PH_ADDR && phase_r != PH_CMD &&
                 phase_r != PH_COUNT && phase_r != PH_DATA) begin
      phase_nxt = PH_IDLE;
    end else begin
      prev_nxt = in_byte_r;
      priority if (prev_r == FESC_BYTE) begin
        priority if (in_byte_r == TFESC_BYTE) begin
          ub = FESC_BYTE;
        end else if (in_byte_r == TFEND_BYTE) begin
          ub = FEND_BYTE;
        end else begin
          stop      = 1'b1;
          res_valid = 1'b1;
          res_kind  = KIND_ERROR;
          phase_nxt = PH_IDLE;
        end
      end else if (in_byte_r == FESC_BYTE) begin
        // lone escape: only remembered
        stop = 1'b1;
      end else begin
        ub = in_byte_r;
      end

      if (!stop && phase_r == PH_ADDR) begin
        if (ub[7]) begin
          stop = 1'b1;
          if (ub[6:0] == 7'd0 || ub[6:0] == own_addr_r) begin
            fold_en   = 1'b1;
            fold_byte = {1'b0, ub[6:0]};
            phase_nxt = PH_CMD;
          end else begin
            phase_nxt = PH_IDLE;
          end
        end else begin
          // no address byte: this one is already the command
          act_phase = PH_CMD;
        end
      end

      if (!stop) begin
        fold_byte = ub;
        unique case (act_phase)
          PH_CMD: begin
            if (ub[7]) begin
              res_valid = 1'b1;
              res_kind  = KIND_ERROR;
              phase_nxt = PH_IDLE;
            end else begin
              cmd_nxt   = ub[6:0];
              fold_en   = 1'b1;
              phase_nxt = PH_COUNT;
            end
          end
          PH_COUNT: begin
            if ({1'b0, ub} > MAX_PAYLOAD) begin
              res_valid = 1'b1;
              res_kind  = KIND_ERROR;
              phase_nxt = PH_IDLE;
            end else begin
              len_nxt   = ub;
              fold_en   = 1'b1;
              ptr_nxt   = '0;
              phase_nxt = PH_DATA;
            end
          end
          PH_DATA: begin
            if (ptr_r < len_r) begin
              ptr_nxt   = ptr_r + 8'd1;
              fold_en   = 1'b1;
              res_valid = 1'b1;
              res_kind  = KIND_DATA;
              res_value = ub;
              res_index = ptr_r;
            end else if (ub != crc_r) begin
              res_valid = 1'b1;
              res_kind  = KIND_ERROR;
              phase_nxt = PH_IDLE;
            end else begin
              res_valid = 1'b1;
              res_kind  = KIND_ACCEPT;
              res_cmd   = cmd_r;
              res_len   = len_r;
              phase_nxt = PH_IDLE;
            end
          end
          default: begin
            phase_nxt = PH_IDLE;
          end
        endcase
      end

      if (fold_en) begin
        crc_nxt = crc_fold(crc_r, fold_byte);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= PH_IDLE;
      prev_r  <= '0;
      crc_r   <= '0;
      cmd_r   <= '0;
      len_r   <= '0;
      ptr_r   <= '0;
    end else if (consume) begin
      phase_r <= phase_nxt;
      prev_r  <= prev_nxt;
      crc_r   <= crc_nxt;
      cmd_r   <= cmd_nxt;
      len_r   <= len_nxt;
      ptr_r   <= ptr_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (consume) begin
      out_valid_r <= res_valid;
    end else if (out_ch.ready) begin
      out_valid_r <= 1'b0;
    end
    if (consume) begin
      out_kind_r  <= res_kind;
      out_value_r <= res_value;
      out_index_r <= res_index;
      out_cmd_r   <= res_cmd;
      out_len_r   <= res_len;
    end
  end

  assign out_ch.valid          = out_valid_r;
  assign out_ch.kind           = out_kind_r;
  assign out_ch.data_value     = out_value_r;
  assign out_ch.data_index     = out_index_r;
  assign out_ch.command_code   = out_cmd_r;
  assign out_ch.payload_length = out_len_r;

endmodule

// ===== rtl/core/wfr_checker.sv =====
// port-level checks for the wake frame receiver, bound to the top level
module wfr_checker import wfr_pkg::*; (
  input logic       clk,
  input logic       rst_n,
  input logic       in_ready,
  input logic       out_valid,
  input logic       out_ready,
  input logic [1:0] out_kind,
  input logic [7:0] out_data_value,
  input logic [7:0] out_data_index,
  input logic [6:0] out_command_code,
  input logic [7:0] out_payload_length
);

  // a stalled result keeps its fields
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_kind) &&
      $stable(out_data_value) && $stable(out_data_index) &&
      $stable(out_command_code) && $stable(out_payload_length))
    else $error("result changed while stalled");

  // the output register drains into the sink, so input never stalls then
  a_in_flow: assert property (@(posedge clk) disable iff (!rst_n)
    out_ready |-> in_ready)
    else $error("input stalled with sink ready");

  // fields that do not belong to a result kind stay zero
  a_fields: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |->
      (out_kind == KIND_DATA && out_command_code == 7'd0 && out_payload_length == 8'd0) ||
      (out_kind == KIND_ACCEPT && out_data_value == 8'd0 && out_data_index == 8'd0) ||
      (out_kind == KIND_ERROR && out_data_value == 8'd0 && out_data_index == 8'd0 &&
       out_command_code == 7'd0 && out_payload_length == 8'd0))
    else $error("result fields inconsistent with kind");

  a_reset: assert property (@(posedge clk) !rst_n |=> !out_valid)
    else $error("result valid right after reset");

endmodule

bind wake_frame_receiver wfr_checker u_wfr_checker (
  .clk                (clk),
  .rst_n              (rst_n),
  .in_ready           (in_ch.ready),
  .out_valid          (out_ch.valid),
  .out_ready          (out_ch.ready),
  .out_kind           (out_ch.kind),
  .out_data_value     (out_ch.data_value),
  .out_data_index     (out_ch.data_index),
  .out_command_code   (out_ch.command_code),
  .out_payload_length (out_ch.payload_length)
);

// ===== tb/wake_frame_receiver_tb.sv =====
// self-checking testbench for the wake frame receiver: framed byte stimulus and result scoreboard
`timescale 1ns / 1ps

module wake_frame_receiver_tb;
  import wfr_pkg::*;

  typedef struct packed {
    kind_t      kind;
    logic [7:0] data_value;
    logic [7:0] data_index;
    logic [6:0] command_code;
    logic [7:0] payload_length;
  } frame_result_t;

  // tracks the receiver's frame decode and holds the results it still owes
  class frame_tracker;
    logic [6:0]      own_addr;
    phase_t          rx_phase;
    logic [7:0]      prev_byte;
    logic [7:0]      crc;
    logic [6:0]      cmd;
    logic [7:0]      len;
    logic [7:0]      ptr;
    frame_result_t   results_due[$];
    int              mismatches;

    function new();
      own_addr   = '0;
      rx_phase   = PH_IDLE;
      prev_byte  = '0;
      crc        = '0;
      cmd        = '0;
      len        = '0;
      ptr        = '0;
      mismatches = 0;
    endfunction

    function void set_address(logic [6:0] a);
      own_addr = a;
    endfunction

    // maxim crc-8, reflected polynomial, lsb first
    static function logic [7:0] fold_crc(logic [7:0] c, logic [7:0] d);
      logic mix;
      for (int k = 0; k < 8; k++) begin
        mix = c[0] ^ d[k];
        c = c >> 1;
        if (mix) c = c ^ 8'h8C;
      end
      return c;
    endfunction

    function void push_result(kind_t k, logic [7:0] v, logic [7:0] i, logic [6:0] c,
                              logic [7:0] l);
      frame_result_t r;
      r.kind           = k;
      r.data_value     = v;
      r.data_index     = i;
      r.command_code   = c;
      r.payload_length = l;
      results_due.push_back(r);
    endfunction

    function void abort_frame();
      rx_phase = PH_IDLE;
      push_result(KIND_ERROR, '0, '0, '0, '0);
    endfunction

    function void take_byte(logic [7:0] raw);
      logic [7:0] b;
      logic [7:0] last;
      b    = raw;
      last = prev_byte;
      if (b == FEND_BYTE) begin
        prev_byte = b;
        crc       = fold_crc(CRC_PRESET, b);
        rx_phase  = PH_ADDR;
        return;
      end
      // outside a frame everything but frame start is dropped, history kept
      if (rx_phase == PH_IDLE) return;
      prev_byte = b;
      if (last == FESC_BYTE) begin
        if (b == TFESC_BYTE) b = FESC_BYTE;
        else if (b == TFEND_BYTE) b = FEND_BYTE;
        else begin
          abort_frame();
          return;
        end
      end else if (b == FESC_BYTE) begin
        return;
      end
      if (rx_phase == PH_ADDR) begin
        if (b[7]) begin
          if (b[6:0] == 7'd0 || b[6:0] == own_addr) begin
            crc      = fold_crc(crc, {1'b0, b[6:0]});
            rx_phase = PH_CMD;
          end else begin
            rx_phase = PH_IDLE;
          end
          return;
        end
        // no address byte: this one is already the command
        rx_phase = PH_CMD;
      end
      case (rx_phase)
        PH_CMD: begin
          if (b[7]) abort_frame();
          else begin
            cmd      = b[6:0];
            crc      = fold_crc(crc, b);
            rx_phase = PH_COUNT;
          end
        end
        PH_COUNT: begin
          if ({1'b0, b} > MAX_PAYLOAD) abort_frame();
          else begin
            len      = b;
            crc      = fold_crc(crc, b);
            ptr      = '0;
            rx_phase = PH_DATA;
          end
        end
        default: begin
          if (ptr < len) begin
            push_result(KIND_DATA, b, ptr, '0, '0);
            ptr = ptr + 8'd1;
            crc = fold_crc(crc, b);
          end else if (b != crc) begin
            abort_frame();
          end else begin
            rx_phase = PH_IDLE;
            push_result(KIND_ACCEPT, '0, '0, cmd, len);
          end
        end
      endcase
    endfunction

    function void check_result(frame_result_t got);
      frame_result_t want;
      if (results_due.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("%0t: unexpected result kind=%0d value=%h index=%0d cmd=%h len=%0d",
                   $realtime, got.kind, got.data_value, got.data_index, got.command_code,
                   got.payload_length);
        return;
      end
      want = results_due.pop_front();
      if (got !== want) begin
        mismatches++;
        if (mismatches <= 10) begin
          $display("%0t: result mismatch, expected kind=%0d value=%h index=%0d cmd=%h len=%0d",
                   $realtime, want.kind, want.data_value, want.data_index,
                   want.command_code, want.payload_length);
          $display("  got kind=%0d value=%h index=%0d cmd=%h len=%0d",
                   got.kind, got.data_value, got.data_index, got.command_code,
                   got.payload_length);
        end
      end
    endfunction
  endclass

  logic clk = 1'b0;
  logic rst_n;
  logic cfg_we;
  logic [6:0] cfg_wdata;

  wfr_in_if  in_ch ();
  wfr_out_if out_ch ();

  wake_frame_receiver uut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_ch     (in_ch),
    .out_ch    (out_ch),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata)
  );

  always #4 clk = ~clk;

  frame_tracker tracker;
  logic [7:0]   wire_bytes[$];
  int           burst_left = 0;
  int           ready_mode = 0;
  int           mode_left = 0;

  // result side stalls in modes that are chosen at random and change when mode_left runs out
  always @(posedge clk) begin
    if (mode_left == 0) begin
      ready_mode <= $urandom_range(0, 3);
      mode_left  <= $urandom_range(20, 120);
    end else begin
      mode_left <= mode_left - 1;
    end
    case (ready_mode)
      0:       out_ch.ready <= 1'b1;
      1:       out_ch.ready <= ($urandom_range(0, 3) != 0);
      2:       out_ch.ready <= 1'($urandom_range(0, 1));
      default: out_ch.ready <= ((mode_left % 6) < 3);
    endcase
  end

  always @(posedge clk) begin : monitor
    frame_result_t seen;
    if (rst_n) begin
      if (out_ch.valid && out_ch.ready) begin
        seen.kind           = out_ch.kind;
        seen.data_value     = out_ch.data_value;
        seen.data_index     = out_ch.data_index;
        seen.command_code   = out_ch.command_code;
        seen.payload_length = out_ch.payload_length;
        tracker.check_result(seen);
      end
      if (in_ch.valid && in_ch.ready) tracker.take_byte(in_ch.rx_byte);
    end
  end

  function void push_stuffed(logic [7:0] b);
    if (b == FEND_BYTE || b == FESC_BYTE) begin
      wire_bytes.push_back(FESC_BYTE);
      wire_bytes.push_back((b == FEND_BYTE) ? TFEND_BYTE : TFESC_BYTE);
    end else begin
      wire_bytes.push_back(b);
    end
  endfunction

  function void make_frame(bit with_addr, logic [6:0] addr7, logic [7:0] cmd_byte,
                           logic [7:0] len, bit fill_escapes, logic [7:0] crc_flip);
    logic [7:0] c;
    logic [7:0] d;
    wire_bytes.push_back(FEND_BYTE);
    c = frame_tracker::fold_crc(CRC_PRESET, FEND_BYTE);
    if (with_addr) begin
      push_stuffed({1'b1, addr7});
      c = frame_tracker::fold_crc(c, {1'b0, addr7});
    end
    push_stuffed(cmd_byte);
    c = frame_tracker::fold_crc(c, cmd_byte);
    if (cmd_byte[7]) return;
    push_stuffed(len);
    c = frame_tracker::fold_crc(c, len);
    for (int k = 0; k < len; k++) begin
      if (fill_escapes) d = k[0] ? FESC_BYTE : FEND_BYTE;
      else begin
        d = 8'($urandom_range(0, 255));
        if ($urandom_range(0, 4) == 0) d = $urandom_range(0, 1) ? FEND_BYTE : FESC_BYTE;
      end
      push_stuffed(d);
      c = frame_tracker::fold_crc(c, d);
    end
    push_stuffed(c ^ crc_flip);
  endfunction

  function logic [7:0] rand_len();
    return ($urandom_range(0, 3) == 0) ? 8'($urandom_range(0, 40)) : 8'($urandom_range(0, 6));
  endfunction

  function void good_frame(logic [7:0] crc_flip);
    int m;
    m = $urandom_range(0, 3);
    make_frame(m != 0, (m == 1) ? 7'd0 : tracker.own_addr, {1'b0, 7'($urandom)}, rand_len(),
               1'b0, crc_flip);
  endfunction

  function void cut_frame();
    int keep;
    keep = $urandom_range(1, wire_bytes.size() - 1);
    while (wire_bytes.size() > keep) void'(wire_bytes.pop_back());
  endfunction

  function void random_frame();
    int         pick;
    logic [6:0] a;
    logic [7:0] x;
    pick = $urandom_range(0, 99);
    if (pick < 58) begin
      good_frame(8'h00);
    end else if (pick < 68) begin
      good_frame(8'($urandom_range(1, 255)));
    end else if (pick < 74) begin
      do a = 7'($urandom_range(1, 127)); while (a == tracker.own_addr);
      make_frame(1'b1, a, {1'b0, 7'($urandom)}, rand_len(), 1'b0, 8'h00);
    end else if (pick < 80) begin
      make_frame(1'b1, $urandom_range(0, 1) ? 7'd0 : tracker.own_addr,
                 {1'b1, 7'($urandom)}, 8'd0, 1'b0, 8'h00);
    end else if (pick < 88) begin
      // frame broken off by an escape with an illegal follower
      good_frame(8'h00);
      cut_frame();
      do x = 8'($urandom_range(0, 255));
      while (x == FEND_BYTE || x == TFEND_BYTE || x == TFESC_BYTE);
      wire_bytes.push_back(FESC_BYTE);
      wire_bytes.push_back(x);
    end else if (pick < 95) begin
      good_frame(8'h00);
      cut_frame();
    end else begin
      repeat ($urandom_range(1, 6)) wire_bytes.push_back(8'($urandom_range(0, 255)));
    end
  endfunction

  task automatic send_bytes();
    int gap;
    while (wire_bytes.size() != 0) begin
      if (burst_left == 0) begin
        gap = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 6);
        if (gap > 0) begin
          in_ch.valid <= 1'b0;
          repeat (gap) @(posedge clk);
        end
        burst_left = $urandom_range(1, 30);
      end
      in_ch.valid   <= 1'b1;
      in_ch.rx_byte <= wire_bytes.pop_front();
      do @(posedge clk); while (!in_ch.ready);
      burst_left--;
    end
  endtask

  task automatic settle();
    in_ch.valid <= 1'b0;
    while (tracker.results_due.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
  endtask

  task automatic write_address(logic [6:0] a);
    cfg_we    <= 1'b1;
    cfg_wdata <= a;
    @(posedge clk);
    cfg_we <= 1'b0;
    tracker.set_address(a);
  endtask

  initial begin
    #2_000_000;
    $display("wake_frame_receiver verification failed");
    $finish;
  end

  initial begin
    logic [6:0] addr_plan[4];
    int         random_sent;
    bit         max_done;
    tracker        = new();
    rst_n         <= 1'b0;
    in_ch.valid   <= 1'b0;
    in_ch.rx_byte <= '0;
    cfg_we        <= 1'b0;
    cfg_wdata     <= '0;
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;

    write_address(7'h2A);
    // idle noise, addressed and broadcast frames, escaped payload, bad escape,
    // foreign address, addressless command with bad crc, bad command
    wire_bytes.push_back(8'hFF);
    make_frame(1'b1, 7'h2A, 8'h7F, 8'd0, 1'b0, 8'h00);
    make_frame(1'b1, 7'h00, 8'h00, 8'd2, 1'b1, 8'h00);
    wire_bytes.push_back(FEND_BYTE);
    wire_bytes.push_back(FESC_BYTE);
    wire_bytes.push_back(8'h41);
    wire_bytes.push_back(FEND_BYTE);
    wire_bytes.push_back(8'h81);
    wire_bytes.push_back(8'h00);
    make_frame(1'b0, 7'h00, 8'h05, 8'd1, 1'b0, 8'h01);
    make_frame(1'b1, 7'h00, 8'h85, 8'd0, 1'b0, 8'h00);
    send_bytes();
    settle();

    addr_plan   = '{7'h7F, 7'h00, 7'h40, 7'($urandom)};
    random_sent = 0;
    max_done    = 1'b0;
    for (int p = 0; p < 4; p++) begin
      write_address(addr_plan[p]);
      while (random_sent < 163 * (p + 1)) begin
        if (p == 1 && !max_done) begin
          make_frame(1'b1, addr_plan[p], {1'b0, 7'($urandom)}, 8'd255, 1'b0, 8'h00);
          max_done = 1'b1;
        end else begin
          random_frame();
        end
        random_sent += wire_bytes.size();
        send_bytes();
      end
      settle();
    end

    if (tracker.mismatches == 0 && tracker.results_due.size() == 0) begin
      $display("wake_frame_receiver verification clean");
    end else begin
      $display("wake_frame_receiver verification failed");
    end
    $finish;
  end

endmodule

// ===== sim.f =====
rtl/core/wfr_pkg.sv
rtl/core/wfr_ifs.sv
rtl/core/wake_frame_receiver.sv
rtl/core/wfr_checker.sv
tb/wake_frame_receiver_tb.sv
